FILE: sv/pinhole_reprojection_residual_assert.svh
// Assertion macros for the reprojection residual block.
`ifndef PINHOLE_REPROJECTION_RESIDUAL_ASSERT_SVH
`define PINHOLE_REPROJECTION_RESIDUAL_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define PRR_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("prr assertion failed");

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define PRR_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("prr assertion failed");

`endif

FILE: sv/prr_pkg.sv
// Shared constants and helpers for the reprojection residual block.
package prr_pkg;

  localparam int VALUE_WIDTH_DEF   = 48;
  localparam int FRACTION_BITS_DEF = 32;
  localparam int NUM_WORDS         = 16;
  localparam int INDEX_WIDTH       = 4;

  // Latency of the fixed-point multiplier.
  localparam int MUL_LAT = 4;

  // Camera table slots.
  localparam int IDX_TX = 9;
  localparam int IDX_TY = 10;
  localparam int IDX_TZ = 11;
  localparam int IDX_FX = 12;
  localparam int IDX_CX = 13;
  localparam int IDX_FY = 14;
  localparam int IDX_CY = 15;

  // Request function codes.
  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_EVAL  = 1'b1;

  // Latency of the fixed-point divider: input stage, one stage per quotient bit, two
  // stages of rounding and saturation.
  function automatic int div_lat(input int w, input int f);
    return w + f + 3;
  endfunction

endpackage

FILE: sv/prr_if.sv
// Request and result channel interfaces.
interface prr_in_if #(
  parameter int W = prr_pkg::VALUE_WIDTH_DEF
) ();
  logic                                  valid;
  logic                                  ready;
  logic                                  func;
  logic [prr_pkg::INDEX_WIDTH-1:0]       word_index;
  logic signed [W-1:0]                   word_value;
  logic signed [W-1:0]                   point_x;
  logic signed [W-1:0]                   point_y;
  logic signed [W-1:0]                   point_z;
  logic signed [W-1:0]                   obs_u;
  logic signed [W-1:0]                   obs_v;

  modport source (
    output valid, func, word_index, word_value, point_x, point_y, point_z, obs_u, obs_v,
    input  ready
  );
  modport sink (
    input  valid, func, word_index, word_value, point_x, point_y, point_z, obs_u, obs_v,
    output ready
  );
endinterface

interface prr_out_if #(
  parameter int W = prr_pkg::VALUE_WIDTH_DEF
) ();
  logic                valid;
  logic                ready;
  logic signed [W-1:0] residual_u;
  logic signed [W-1:0] residual_v;
  logic                saturated;

  modport source (output valid, residual_u, residual_v, saturated, input ready);
  modport sink   (input valid, residual_u, residual_v, saturated, output ready);
endinterface

FILE: sv/prr_fxmul.sv
// Pipelined signed fixed-point multiplier with rounding and saturation.
module prr_fxmul #(
  parameter int W = prr_pkg::VALUE_WIDTH_DEF,
  parameter int F = prr_pkg::FRACTION_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                en_i,
  input  logic signed [W-1:0] a_i,
  input  logic signed [W-1:0] b_i,
  output logic signed [W-1:0] p_o,
  output logic                sat_o
);

  localparam int H  = (W + 1) / 2;
  localparam int HB = W - H;
  localparam logic [2*W-1:0] RND = {{(2*W-1){1'b0}}, 1'b1} << (F - 1);
  localparam logic [2*W-1:0] LIM_P = {{(W+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic [2*W-1:0] LIM_N = {{W{1'b0}}, 1'b1, {(W-1){1'b0}}};

  function automatic logic [W-1:0] mag(input logic signed [W-1:0] a);
    logic [W-1:0] u;
    u = a;
    return a[W-1] ? (~u + 1'b1) : u;
  endfunction

  logic [W-1:0]      ma_q, mb_q;
  logic              neg1_q, neg2_q, neg3_q;
  logic [2*H-1:0]    ll_q;
  logic [W-1:0]      lh_q, hl_q;
  logic [2*HB-1:0]   hh_q;
  logic [2*W-1:0]    prod_q;
  logic [W:0]        mid;
  logic [2*W-1:0]    prod_d;
  logic [2*W-1:0]    shifted;
  logic              over;
  logic [W-1:0]      lim_w, val;
  logic signed [W-1:0] p_q;
  logic              sat_q;

  always_comb begin
    mid    = {1'b0, lh_q} + {1'b0, hl_q};
    prod_d = {{(2*W-2*H){1'b0}}, ll_q}
           + ({{(W-1){1'b0}}, mid} << H)
           + {hh_q, {(2*H){1'b0}}}
           + RND;
  end

  always_comb begin
    shifted = prod_q >> F;
    over    = shifted > (neg3_q ? LIM_N : LIM_P);
    lim_w   = neg3_q ? LIM_N[W-1:0] : LIM_P[W-1:0];
    val     = over ? lim_w : shifted[W-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ma_q   <= mag(a_i);
      mb_q   <= mag(b_i);
      neg1_q <= a_i[W-1] ^ b_i[W-1];
      ll_q   <= ma_q[H-1:0] * mb_q[H-1:0];
      lh_q   <= ma_q[H-1:0] * mb_q[W-1:H];
      hl_q   <= ma_q[W-1:H] * mb_q[H-1:0];
      hh_q   <= ma_q[W-1:H] * mb_q[W-1:H];
      neg2_q <= neg1_q;
      prod_q <= prod_d;
      neg3_q <= neg2_q;
      p_q    <= neg3_q ? (~val + 1'b1) : val;
      sat_q  <= over;
    end
  end

  assign p_o   = p_q;
  assign sat_o = sat_q;

endmodule

FILE: sv/prr_fxdiv.sv
// Pipelined signed fixed-point divider, one quotient bit per stage, rounded and saturated.
module prr_fxdiv #(
  parameter int W = prr_pkg::VALUE_WIDTH_DEF,
  parameter int F = prr_pkg::FRACTION_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                en_i,
  input  logic signed [W-1:0] n_i,
  input  logic signed [W-1:0] d_i,
  output logic signed [W-1:0] q_o,
  output logic                sat_o
);

  localparam int N = W + F;
  localparam logic [N:0] LIM_P = {{(F+2){1'b0}}, {(W-1){1'b1}}};
  localparam logic [N:0] LIM_N = {{(F+1){1'b0}}, 1'b1, {(W-1){1'b0}}};

  function automatic logic [W-1:0] mag(input logic signed [W-1:0] a);
    logic [W-1:0] u;
    u = a;
    return a[W-1] ? (~u + 1'b1) : u;
  endfunction

  logic [W-1:0] rem_q [N+1];
  logic [N-1:0] num_q [N];
  logic [N-1:0] quo_q [N+1];
  logic [W-1:0] dm_q  [N+1];
  logic         neg_q [N+1];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= '0;
      num_q[0] <= {mag(n_i), {F{1'b0}}};
      quo_q[0] <= '0;
      dm_q[0]  <= mag(d_i);
      neg_q[0] <= n_i[W-1] ^ d_i[W-1];
    end
  end

  for (genvar k = 1; k <= N; k++) begin : g_step
    logic [W:0] r2, df;
    logic       ge;
    always_comb begin
      r2 = {rem_q[k-1], num_q[k-1][N-1]};
      ge = r2 >= {1'b0, dm_q[k-1]};
      df = r2 - {1'b0, dm_q[k-1]};
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= ge ? df[W-1:0] : r2[W-1:0];
        quo_q[k] <= {quo_q[k-1][N-2:0], ge};
        dm_q[k]  <= dm_q[k-1];
        neg_q[k] <= neg_q[k-1];
      end
    end
    if (k < N) begin : g_num
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          num_q[k] <= num_q[k-1] << 1;
        end
      end
    end
  end

  logic         up;
  logic [N:0]   qr_q;
  logic         negr_q;
  logic         over;
  logic [W-1:0] val;
  logic signed [W-1:0] q_q;
  logic         sat_q;

  // Round half away from zero: bump when twice the remainder reaches the divisor.
  assign up = {rem_q[N], 1'b0} >= {1'b0, dm_q[N]};

  always_comb begin
    over = qr_q > (negr_q ? LIM_N : LIM_P);
    val  = over ? (negr_q ? LIM_N[W-1:0] : LIM_P[W-1:0]) : qr_q[W-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      qr_q   <= {1'b0, quo_q[N]} + {{N{1'b0}}, up};
      negr_q <= neg_q[N];
      q_q    <= negr_q ? (~val + 1'b1) : val;
      sat_q  <= over;
    end
  end

  assign q_o   = q_q;
  assign sat_o = sat_q;

endmodule

FILE: sv/pinhole_reprojection_residual.sv
// Top level: pinhole camera reprojection residual pipeline with camera table.
//
//   channel   dir   payload                                   handshake
//   in_i      in    func, word_index, word_value, point, obs  valid/ready
//   out_o     out   residual_u, residual_v, saturated          valid/ready
//
// One request per cycle while the pipeline advances. The time from a point to its result
// is set mostly by the divider, one quotient bit per stage.
// Table writes land at the accepting edge; later points see the new word.
// Reset clears the table and all valid bits. A stalled result holds the output
// register; the pipeline keeps moving while its last stage is empty, then stops.
module pinhole_reprojection_residual #(
  parameter int VALUE_WIDTH   = prr_pkg::VALUE_WIDTH_DEF,
  parameter int FRACTION_BITS = prr_pkg::FRACTION_BITS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  prr_in_if.sink    in_i,
  prr_out_if.source out_o
);

  localparam int W       = VALUE_WIDTH;
  localparam int F       = FRACTION_BITS;
  localparam int ML      = prr_pkg::MUL_LAT;
  localparam int DL      = prr_pkg::div_lat(W, F);
  localparam logic [W-1:0] VMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] VMIN = {1'b1, {(W-1){1'b0}}};
  localparam longint unsigned EPS_RAW = ((64'd1 << F) + 64'd50000) / 64'd100000;
  localparam longint unsigned EPS_VAL = (EPS_RAW == 0) ? 64'd1 : EPS_RAW;
  localparam logic signed [W-1:0] EPS = EPS_VAL[W-1:0];

  typedef struct packed {
    logic                v;
    logic                sat;
    logic signed [W-1:0] tx;
    logic signed [W-1:0] ty;
    logic signed [W-1:0] tz;
    logic signed [W-1:0] fx;
    logic signed [W-1:0] cx;
    logic signed [W-1:0] fy;
    logic signed [W-1:0] cy;
    logic signed [W-1:0] ou;
    logic signed [W-1:0] ov;
    logic signed [W-1:0] qz;
  } side_t;

  function automatic logic [W:0] sadd(input logic signed [W-1:0] a, input logic signed [W-1:0] b);
    logic [W:0] s;
    s = {a[W-1], a} + {b[W-1], b};
    if (s[W] != s[W-1]) return {1'b1, s[W] ? VMIN : VMAX};
    return {1'b0, s[W-1:0]};
  endfunction

  function automatic logic [W:0] ssub(input logic signed [W-1:0] a, input logic signed [W-1:0] b);
    logic [W:0] s;
    s = {a[W-1], a} - {b[W-1], b};
    if (s[W] != s[W-1]) return {1'b1, s[W] ? VMIN : VMAX};
    return {1'b0, s[W-1:0]};
  endfunction

  logic en, acc;
  logic signed [W-1:0] cam_q [prr_pkg::NUM_WORDS];

  side_t sf_q;
  logic  out_valid_q;

  // Advance unless a finished result sits in the last stage behind a held output.
  assign en    = out_o.ready || !out_valid_q || !sf_q.v;
  assign acc   = in_i.valid && en;
  assign in_i.ready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < prr_pkg::NUM_WORDS; i++) cam_q[i] <= '0;
    end else if (acc && in_i.func == prr_pkg::FUNC_WRITE) begin
      cam_q[in_i.word_index] <= in_i.word_value;
    end
  end

  // Rotation products.
  logic signed [W-1:0] pt [3];
  logic signed [W-1:0] prod [3][3];
  logic                psat [3][3];

  assign pt[0] = in_i.point_x;
  assign pt[1] = in_i.point_y;
  assign pt[2] = in_i.point_z;

  for (genvar r = 0; r < 3; r++) begin : g_row
    for (genvar c = 0; c < 3; c++) begin : g_col
      prr_fxmul #(.W(W), .F(F)) u_mul (
        .clk_i (clk_i),
        .en_i  (en),
        .a_i   (cam_q[3*r+c]),
        .b_i   (pt[c]),
        .p_o   (prod[r][c]),
        .sat_o (psat[r][c])
      );
    end
  end

  side_t s1_in;
  side_t d1_q [ML];

  always_comb begin
    s1_in     = '0;
    s1_in.v   = acc && in_i.func == prr_pkg::FUNC_EVAL;
    s1_in.tx  = cam_q[prr_pkg::IDX_TX];
    s1_in.ty  = cam_q[prr_pkg::IDX_TY];
    s1_in.tz  = cam_q[prr_pkg::IDX_TZ];
    s1_in.fx  = cam_q[prr_pkg::IDX_FX];
    s1_in.cx  = cam_q[prr_pkg::IDX_CX];
    s1_in.fy  = cam_q[prr_pkg::IDX_FY];
    s1_in.cy  = cam_q[prr_pkg::IDX_CY];
    s1_in.ou  = in_i.obs_u;
    s1_in.ov  = in_i.obs_v;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < ML; k++) d1_q[k] <= '0;
    end else if (en) begin
      d1_q[0] <= s1_in;
      for (int k = 1; k < ML; k++) d1_q[k] <= d1_q[k-1];
    end
  end

  // Row sums: two products, then the third, then the translation.
  side_t               sa1_q, sa2_q, sa3_q;
  side_t               sa1_d, sa2_d, sa3_d;
  logic signed [W-1:0] a1_q [3];
  logic signed [W-1:0] p2_q [3];
  logic signed [W-1:0] a2_q [3];
  logic signed [W-1:0] q_q  [3];
  logic [W:0]          s_a1 [3];
  logic [W:0]          s_a2 [3];
  logic [W:0]          s_a3 [3];
  logic signed [W-1:0] tvec [3];
  logic                sat_a1, sat_a2, sat_a3;

  assign tvec[0] = sa2_q.tx;
  assign tvec[1] = sa2_q.ty;
  assign tvec[2] = sa2_q.tz;

  always_comb begin
    sat_a1 = 1'b0;
    sat_a2 = 1'b0;
    sat_a3 = 1'b0;
    for (int r = 0; r < 3; r++) begin
      s_a1[r] = sadd(prod[r][0], prod[r][1]);
      s_a2[r] = sadd(a1_q[r], p2_q[r]);
      s_a3[r] = sadd(a2_q[r], tvec[r]);
      sat_a1  = sat_a1 | s_a1[r][W] | psat[r][0] | psat[r][1] | psat[r][2];
      sat_a2  = sat_a2 | s_a2[r][W];
      sat_a3  = sat_a3 | s_a3[r][W];
    end
    sa1_d     = d1_q[ML-1];
    sa1_d.sat = sat_a1;
    sa2_d     = sa1_q;
    sa2_d.sat = sa1_q.sat | sat_a2;
    sa3_d     = sa2_q;
    sa3_d.sat = sa2_q.sat | sat_a3;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sa1_q <= '0;
      sa2_q <= '0;
      sa3_q <= '0;
    end else if (en) begin
      sa1_q <= sa1_d;
      sa2_q <= sa2_d;
      sa3_q <= sa3_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int r = 0; r < 3; r++) begin
        a1_q[r] <= s_a1[r][W-1:0];
        p2_q[r] <= prod[r][2];
        a2_q[r] <= s_a2[r][W-1:0];
        q_q[r]  <= s_a3[r][W-1:0];
      end
    end
  end

  // Depth clamp and focal products.
  logic signed [W-1:0] qz_c;
  side_t               s2_in;
  side_t               d2_q [ML];
  logic signed [W-1:0] num_u, num_v;
  logic                nsat_u, nsat_v;

  always_comb begin
    qz_c = q_q[2];
    if (!q_q[2][W-1]) begin
      if (q_q[2] < EPS) qz_c = EPS;
    end else if (q_q[2] > -EPS) begin
      qz_c = -EPS;
    end
    s2_in    = sa3_q;
    s2_in.qz = qz_c;
  end

  prr_fxmul #(.W(W), .F(F)) u_mul_u (
    .clk_i (clk_i),
    .en_i  (en),
    .a_i   (sa3_q.fx),
    .b_i   (q_q[0]),
    .p_o   (num_u),
    .sat_o (nsat_u)
  );

  prr_fxmul #(.W(W), .F(F)) u_mul_v (
    .clk_i (clk_i),
    .en_i  (en),
    .a_i   (sa3_q.fy),
    .b_i   (q_q[1]),
    .p_o   (num_v),
    .sat_o (nsat_v)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < ML; k++) d2_q[k] <= '0;
    end else if (en) begin
      d2_q[0] <= s2_in;
      for (int k = 1; k < ML; k++) d2_q[k] <= d2_q[k-1];
    end
  end

  // Perspective divide.
  side_t               s3_in;
  side_t               d3_q [DL];
  logic signed [W-1:0] quo_u, quo_v;
  logic                dsat_u, dsat_v;

  always_comb begin
    s3_in     = d2_q[ML-1];
    s3_in.sat = d2_q[ML-1].sat | nsat_u | nsat_v;
  end

  prr_fxdiv #(.W(W), .F(F)) u_div_u (
    .clk_i (clk_i),
    .en_i  (en),
    .n_i   (num_u),
    .d_i   (d2_q[ML-1].qz),
    .q_o   (quo_u),
    .sat_o (dsat_u)
  );

  prr_fxdiv #(.W(W), .F(F)) u_div_v (
    .clk_i (clk_i),
    .en_i  (en),
    .n_i   (num_v),
    .d_i   (d2_q[ML-1].qz),
    .q_o   (quo_v),
    .sat_o (dsat_v)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < DL; k++) d3_q[k] <= '0;
    end else if (en) begin
      d3_q[0] <= s3_in;
      for (int k = 1; k < DL; k++) d3_q[k] <= d3_q[k-1];
    end
  end

  // Principal point, then observation.
  logic [W:0]          s_u1, s_v1, s_u2, s_v2;
  logic signed [W-1:0] u1_q, v1_q;
  logic signed [W-1:0] ru_q, rv_q;
  logic                osat_q;
  side_t               sf_d;

  assign s_u1 = sadd(quo_u, d3_q[DL-1].cx);
  assign s_v1 = sadd(quo_v, d3_q[DL-1].cy);
  assign s_u2 = ssub(u1_q, sf_q.ou);
  assign s_v2 = ssub(v1_q, sf_q.ov);

  always_comb begin
    sf_d     = d3_q[DL-1];
    sf_d.sat = d3_q[DL-1].sat | dsat_u | dsat_v | s_u1[W] | s_v1[W];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sf_q <= '0;
    end else if (en) begin
      sf_q <= sf_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      u1_q <= s_u1[W-1:0];
      v1_q <= s_v1[W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_valid_q || out_o.ready) begin
      out_valid_q <= sf_q.v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || out_o.ready) begin
      ru_q   <= s_u2[W-1:0];
      rv_q   <= s_v2[W-1:0];
      osat_q <= sf_q.sat | s_u2[W] | s_v2[W];
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.residual_u = ru_q;
  assign out_o.residual_v = rv_q;
  assign out_o.saturated  = osat_q;

endmodule

FILE: sv/prr_checker.sv
// Port-level checks for the reprojection residual block, bound to the top level.
`include "pinhole_reprojection_residual_assert.svh"

module prr_checker #(
  parameter int W = prr_pkg::VALUE_WIDTH_DEF
) (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         in_ready_i,
  input logic         out_valid_i,
  input logic         out_ready_i,
  input logic [W-1:0] residual_u_i,
  input logic [W-1:0] residual_v_i,
  input logic         saturated_i
);

  // A held result keeps its value.
  `PRR_ASSERT_NXT(a_out_hold, out_valid_i && !out_ready_i,
    out_valid_i && $stable(residual_u_i) && $stable(residual_v_i) && $stable(saturated_i))

  // A taken output lets the pipeline move, so requests are taken too.
  `PRR_ASSERT_IMP(a_ready_follows_out, out_ready_i, in_ready_i)

  // An empty output register never blocks requests.
  `PRR_ASSERT_IMP(a_ready_when_empty, !out_valid_i, in_ready_i)

endmodule

bind pinhole_reprojection_residual prr_checker #(.W(VALUE_WIDTH)) u_prr_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_ready_i   (in_i.ready),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .residual_u_i (out_o.residual_u),
  .residual_v_i (out_o.residual_v),
  .saturated_i  (out_o.saturated)
);

FILE: verif/pinhole_reprojection_residual_tb.sv
// Self-checking testbench for the pinhole reprojection residual block.
`timescale 1ns / 100ps

module pinhole_reprojection_residual_tb;

  localparam int W = prr_pkg::VALUE_WIDTH_DEF;
  localparam int F = prr_pkg::FRACTION_BITS_DEF;
  localparam longint VMAX = (64'sd1 <<< (W - 1)) - 1;
  localparam longint VMIN = -VMAX - 1;
  localparam longint EPS = ((64'sd1 <<< F) + 50000) / 100000;
  localparam longint ONE = 64'sd1 <<< F;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 250;
  localparam int NUM_RANDOM = 450;

  typedef struct {
    logic           func;
    logic [3:0]     idx;
    longint         val;
    longint         px, py, pz, ou, ov;
    bit             typed;
    longint         eu, ev;
    bit             es;
  } request_t;

  typedef struct {
    logic signed [W-1:0] u;
    logic signed [W-1:0] v;
    logic                sat;
  } residual_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  prr_in_if  #(.W(W)) in_if ();
  prr_out_if #(.W(W)) out_if ();

  pinhole_reprojection_residual uut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_if),
    .out_o (out_if)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  longint    cam_table [prr_pkg::NUM_WORDS];
  residual_t residual_q [$];
  request_t  directed [$];
  int        fails = 0;
  int        idle_cycles = 0;
  bit        no_idle = 1'b0;
  int        out_stall = 0;

  // ---------------- fixed-point predictor ----------------
  function automatic longint sext_w(input longint v);
    logic signed [W-1:0] t;
    t = v[W-1:0];
    return longint'(t);
  endfunction

  function automatic longint clip_w(input longint v, inout bit sat);
    if (v > VMAX) begin
      sat = 1'b1;
      return VMAX;
    end
    if (v < VMIN) begin
      sat = 1'b1;
      return VMIN;
    end
    return v;
  endfunction

  function automatic longint finish_mag(input bit neg, input logic [127:0] m, inout bit sat);
    logic [127:0] lim;
    lim = neg ? 128'(VMAX) + 1 : 128'(VMAX);
    if (m > lim) begin
      sat = 1'b1;
      m = lim;
    end
    return neg ? -longint'(m[63:0]) : longint'(m[63:0]);
  endfunction

  function automatic longint fixed_mul(input longint a, input longint b, inout bit sat);
    logic [127:0] p;
    logic [63:0]  ma, mb;
    ma = (a < 0) ? -a : a;
    mb = (b < 0) ? -b : b;
    p = 128'(ma) * 128'(mb) + (128'd1 << (F - 1));
    return finish_mag((a < 0) != (b < 0), p >> F, sat);
  endfunction

  function automatic longint fixed_div(input longint n, input longint d, inout bit sat);
    logic [127:0] num, q, r;
    logic [63:0]  nm, dm;
    nm = (n < 0) ? -n : n;
    dm = (d < 0) ? -d : d;
    if (dm == 0) begin
      sat = 1'b1;
      return (n < 0) ? VMIN : VMAX;
    end
    num = 128'(nm) << F;
    q = num / 128'(dm);
    r = num % 128'(dm);
    if (r >= 128'(dm) - r) q = q + 1;
    return finish_mag((n < 0) != (d < 0), q, sat);
  endfunction

  function automatic longint camera_row(input int base, input longint x, input longint y,
                                        input longint z, input longint t, inout bit sat);
    longint acc;
    acc = fixed_mul(cam_table[base], x, sat);
    acc = clip_w(acc + fixed_mul(cam_table[base + 1], y, sat), sat);
    acc = clip_w(acc + fixed_mul(cam_table[base + 2], z, sat), sat);
    return clip_w(acc + t, sat);
  endfunction

  function automatic residual_t predict_residual(input request_t r);
    residual_t res;
    bit        sat;
    longint    qx, qy, qz, u, v;
    sat = 1'b0;
    qx = camera_row(0, r.px, r.py, r.pz, cam_table[prr_pkg::IDX_TX], sat);
    qy = camera_row(3, r.px, r.py, r.pz, cam_table[prr_pkg::IDX_TY], sat);
    qz = camera_row(6, r.px, r.py, r.pz, cam_table[prr_pkg::IDX_TZ], sat);
    // push depth away from zero; this is not a saturation
    if (qz >= 0) begin
      if (qz < EPS) qz = EPS;
    end else if (qz > -EPS) begin
      qz = -EPS;
    end
    u = fixed_div(fixed_mul(cam_table[prr_pkg::IDX_FX], qx, sat), qz, sat);
    u = clip_w(u + cam_table[prr_pkg::IDX_CX], sat);
    v = fixed_div(fixed_mul(cam_table[prr_pkg::IDX_FY], qy, sat), qz, sat);
    v = clip_w(v + cam_table[prr_pkg::IDX_CY], sat);
    u = clip_w(u - r.ou, sat);
    v = clip_w(v - r.ov, sat);
    res.u = u[W-1:0];
    res.v = v[W-1:0];
    res.sat = sat;
    return res;
  endfunction

  // ---------------- random helpers ----------------
  function automatic longint rand_signed(input int bits);
    longint r;
    r = {$urandom, $urandom};
    return r >>> (64 - bits);
  endfunction

  function automatic longint rand_word(input int idx);
    if ($urandom_range(0, 29) == 0) return rand_signed(W);
    if (idx < 9) return rand_signed(F + 1);
    if (idx < 12) return rand_signed(F + 4);
    if (idx == prr_pkg::IDX_FX || idx == prr_pkg::IDX_FY) return ONE * $urandom_range(100, 900);
    return rand_signed(F + 10);
  endfunction

  function automatic int gap_len();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // fields are taken as the block sees them: the low W bits, sign-extended
  function automatic request_t make_row(input logic func, input int idx, input longint val,
                                        input longint px, input longint py, input longint pz,
                                        input longint ou, input longint ov);
    request_t r;
    r.func = func;
    r.idx = idx[3:0];
    r.val = sext_w(val);
    r.px = sext_w(px);
    r.py = sext_w(py);
    r.pz = sext_w(pz);
    r.ou = sext_w(ou);
    r.ov = sext_w(ov);
    r.typed = 1'b0;
    r.eu = 0;
    r.ev = 0;
    r.es = 1'b0;
    return r;
  endfunction

  // ---------------- request driver ----------------
  task automatic send(input request_t r);
    int n;
    residual_t e;
    n = gap_len();
    repeat (n) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid      <= 1'b1;
    in_if.func       <= r.func;
    in_if.word_index <= r.idx;
    in_if.word_value <= r.val[W-1:0];
    in_if.point_x    <= r.px[W-1:0];
    in_if.point_y    <= r.py[W-1:0];
    in_if.point_z    <= r.pz[W-1:0];
    in_if.obs_u      <= r.ou[W-1:0];
    in_if.obs_v      <= r.ov[W-1:0];
    do @(posedge clk); while (!in_if.ready);
    if (r.func == prr_pkg::FUNC_WRITE) begin
      cam_table[r.idx] = r.val;
    end else begin
      if (r.typed) begin
        e.u = r.eu[W-1:0];
        e.v = r.ev[W-1:0];
        e.sat = r.es;
      end else begin
        e = predict_residual(r);
      end
      residual_q.push_back(e);
    end
  endtask

  // ---------------- result sink and checker ----------------
  always @(posedge clk) begin
    if (no_idle || out_stall == 0) begin
      out_if.ready <= 1'b1;
      if (!no_idle && $urandom_range(0, 9) == 0) begin
        out_stall <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60)
                                                 : $urandom_range(1, 3);
      end
    end else begin
      out_if.ready <= 1'b0;
      out_stall <= out_stall - 1;
    end
  end

  always @(posedge clk) begin
    residual_t e;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (residual_q.size() == 0) begin
        $error("result with nothing expected: residual_u %0d", out_if.residual_u);
        fails++;
      end else begin
        e = residual_q.pop_front();
        if (out_if.residual_u !== e.u) begin
          $error("residual_u expected %0d actual %0d", e.u, out_if.residual_u);
          fails++;
        end
        if (out_if.residual_v !== e.v) begin
          $error("residual_v expected %0d actual %0d", e.v, out_if.residual_v);
          fails++;
        end
        if (out_if.saturated !== e.sat) begin
          $error("saturated expected %0d actual %0d", e.sat, out_if.saturated);
          fails++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) || !rst_n) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  // ---------------- stimulus ----------------
  initial begin
    request_t r;
    int       sel;
    int       idx;
    in_if.valid      = 1'b0;
    in_if.func       = prr_pkg::FUNC_WRITE;
    in_if.word_index = '0;
    in_if.word_value = '0;
    in_if.point_x    = '0;
    in_if.point_y    = '0;
    in_if.point_z    = '0;
    in_if.obs_u      = '0;
    in_if.obs_v      = '0;
    out_if.ready     = 1'b0;
    foreach (cam_table[i]) cam_table[i] = 0;

    // empty table after reset: projection is zero, residual is minus the observation
    r = make_row(prr_pkg::FUNC_EVAL, 0, 0, 0, 0, 0, 0, 0);
    r.typed = 1'b1;
    directed.push_back(r);
    r = make_row(prr_pkg::FUNC_EVAL, 15, VMAX, VMAX, VMIN, VMAX, VMIN, VMAX);
    r.typed = 1'b1;
    r.eu = VMAX;
    r.ev = -VMAX;
    r.es = 1'b1;
    directed.push_back(r);
    r = make_row(prr_pkg::FUNC_EVAL, 7, VMIN, VMIN, VMAX, VMIN, VMAX, VMIN);
    r.typed = 1'b1;
    r.eu = -VMAX;
    r.ev = VMAX;
    r.es = 1'b1;
    directed.push_back(r);
    // plain camera: identity rotation, depth offset, usual intrinsics
    directed.push_back(make_row(prr_pkg::FUNC_WRITE, 0, ONE, VMAX, VMIN, VMAX, VMIN, VMAX));
    directed.push_back(make_row(prr_pkg::FUNC_WRITE, 4, ONE, 0, 0, 0, 0, 0));
    directed.push_back(make_row(prr_pkg::FUNC_WRITE, 8, ONE, 0, 0, 0, 0, 0));
    directed.push_back(make_row(prr_pkg::FUNC_WRITE, prr_pkg::IDX_TZ, 4 * ONE, 0, 0, 0, 0, 0));
    directed.push_back(make_row(prr_pkg::FUNC_WRITE, prr_pkg::IDX_FX, 500 * ONE, 0, 0, 0, 0, 0));
    directed.push_back(make_row(prr_pkg::FUNC_WRITE, prr_pkg::IDX_CX, 320 * ONE, 0, 0, 0, 0, 0));
    directed.push_back(make_row(prr_pkg::FUNC_WRITE, prr_pkg::IDX_FY, 500 * ONE, 0, 0, 0, 0, 0));
    directed.push_back(make_row(prr_pkg::FUNC_WRITE, prr_pkg::IDX_CY, 240 * ONE, 0, 0, 0, 0, 0));
    directed.push_back(make_row(prr_pkg::FUNC_EVAL, 3, VMAX, ONE, -ONE / 2, ONE, 300 * ONE,
                                250 * ONE));
    // depth lands at, just below and just above zero
    directed.push_back(make_row(prr_pkg::FUNC_EVAL, 0, 0, ONE, ONE, -4 * ONE, 0, 0));
    directed.push_back(make_row(prr_pkg::FUNC_EVAL, 0, 0, ONE, ONE, -4 * ONE - 5, 0, 0));
    directed.push_back(make_row(prr_pkg::FUNC_EVAL, 0, 0, -ONE, ONE, -4 * ONE + EPS - 1, 0, 0));
    // extreme table words drive the products and sums into saturation
    directed.push_back(make_row(prr_pkg::FUNC_WRITE, 1, VMAX, 0, 0, 0, 0, 0));
    directed.push_back(make_row(prr_pkg::FUNC_WRITE, prr_pkg::IDX_TX, VMIN, 0, 0, 0, 0, 0));
    directed.push_back(make_row(prr_pkg::FUNC_EVAL, 0, 0, VMAX, VMAX, VMAX, VMAX, VMIN));
    directed.push_back(make_row(prr_pkg::FUNC_EVAL, 0, 0, VMIN, VMIN, VMIN, VMIN, VMAX));
    directed.push_back(make_row(prr_pkg::FUNC_WRITE, 7, VMIN, 0, 0, 0, 0, 0));
    directed.push_back(make_row(prr_pkg::FUNC_WRITE, prr_pkg::IDX_FY, VMAX, 0, 0, 0, 0, 0));
    directed.push_back(make_row(prr_pkg::FUNC_EVAL, 0, 0, ONE, VMAX, ONE, 0, 0));
    directed.push_back(make_row(prr_pkg::FUNC_EVAL, 0, 0, -3, 7, VMIN, 1, -1));

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[i]) send(directed[i]);

    // load a sane camera before the random part
    for (int k = 0; k < prr_pkg::NUM_WORDS; k++) begin
      send(make_row(prr_pkg::FUNC_WRITE, k, rand_word(k), rand_signed(W), rand_signed(W),
                    rand_signed(W), rand_signed(W), rand_signed(W)));
    end

    for (int i = 0; i < NUM_RANDOM; i++) begin
      no_idle = (i >= 300 && i < 360);
      if (i == 200) begin
        // hold requests until the pipeline has drained
        in_if.valid <= 1'b0;
        @(posedge clk);
        while (residual_q.size() != 0) @(posedge clk);
      end
      sel = $urandom_range(0, 99);
      idx = $urandom_range(0, prr_pkg::NUM_WORDS - 1);
      if (sel < 12) begin
        r = make_row(prr_pkg::FUNC_WRITE, idx, rand_word(idx), rand_signed(W), rand_signed(W),
                     rand_signed(W), rand_signed(W), rand_signed(W));
      end else if (sel < 20) begin
        r = make_row(prr_pkg::FUNC_EVAL, idx, rand_signed(W), rand_signed(W), rand_signed(W),
                     rand_signed(W), rand_signed(W), rand_signed(W));
      end else if (sel < 26) begin
        // point on the camera plane
        r = make_row(prr_pkg::FUNC_EVAL, idx, rand_signed(W), rand_signed(F + 3),
                     rand_signed(F + 3), -cam_table[prr_pkg::IDX_TZ] + rand_signed(17),
                     rand_signed(F + 10), rand_signed(F + 10));
      end else begin
        r = make_row(prr_pkg::FUNC_EVAL, idx, rand_signed(W), rand_signed(F + 4),
                     rand_signed(F + 4), rand_signed(F + 5) + 40 * ONE, rand_signed(F + 10),
                     rand_signed(F + 10));
      end
      send(r);
    end
    no_idle = 1'b0;
    in_if.valid <= 1'b0;

    while (residual_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fails == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
